@@ rtl/core/i2cebm_pkg.sv @@
// Shared types and constants of the I2C EEPROM byte master.
`timescale 1ns / 1ps

package i2cebm_pkg;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_PHASE_TICKS    = 2'd1;
   localparam logic [1:0] CSR_ACK_WAIT_LIMIT = 2'd2;

   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
   localparam logic [7:0] PHASE_TICKS_RESET    = 8'd1;
   localparam logic [7:0] ACK_WAIT_LIMIT_RESET = 8'd255;

   localparam logic [4:0] PH_IDLE       = 5'd0;
   localparam logic [4:0] PH_ST_SDA_HI  = 5'd1;
   localparam logic [4:0] PH_ST_SCL_HI  = 5'd2;
   localparam logic [4:0] PH_ST_SDA_LO  = 5'd3;
   localparam logic [4:0] PH_WB_SCL_LO  = 5'd4;
   localparam logic [4:0] PH_WB_SDA_BIT = 5'd5;
   localparam logic [4:0] PH_WB_SCL_HI  = 5'd6;
   localparam logic [4:0] PH_WE_SCL_LO  = 5'd7;
   localparam logic [4:0] PH_WE_SDA_HI  = 5'd8;
   localparam logic [4:0] PH_AK_SCL_HI  = 5'd9;
   localparam logic [4:0] PH_AK_WAIT    = 5'd10;
   localparam logic [4:0] PH_AK_SCL_LO  = 5'd11;
   localparam logic [4:0] PH_RB_PREP    = 5'd12;
   localparam logic [4:0] PH_RB_SCL_HI  = 5'd13;
   localparam logic [4:0] PH_RB_SCL_LO  = 5'd14;
   localparam logic [4:0] PH_NK_SDA_HI  = 5'd15;
   localparam logic [4:0] PH_NK_SCL_HI  = 5'd16;
   localparam logic [4:0] PH_NK_SCL_LO  = 5'd17;
   localparam logic [4:0] PH_SP_SDA_LO  = 5'd18;
   localparam logic [4:0] PH_SP_SCL_HI  = 5'd19;
   localparam logic [4:0] PH_SP_SDA_HI  = 5'd20;

   localparam logic [1:0] BYTE_DEVICE  = 2'd0;
   localparam logic [1:0] BYTE_ADDRESS = 2'd1;
   localparam logic [1:0] BYTE_THIRD   = 2'd2;

   typedef struct packed {
      logic [6:0] device_address;
      logic [7:0] phase_ticks;
      logic [7:0] ack_wait_limit;
   } cfg_type;

   typedef struct packed {
      logic [4:0] phase;
      logic [2:0] bit_cnt;
      logic [7:0] shift;
      logic [7:0] hold;
      logic [7:0] ack_cnt;
      logic       op_read;
      logic [7:0] address;
      logic [7:0] data;
      logic [7:0] rx_byte;
      logic [1:0] byte_idx;
      logic       scl;
      logic       sda;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:    PH_IDLE,
      bit_cnt:  3'd0,
      shift:    8'd0,
      hold:     8'd0,
      ack_cnt:  8'd0,
      op_read:  1'b0,
      address:  8'd0,
      data:     8'd0,
      rx_byte:  8'd0,
      byte_idx: BYTE_DEVICE,
      scl:      1'b1,
      sda:      1'b1
   };

endpackage

@@ rtl/core/i2cebm_req_if.sv @@
// Request channel: one tick with command, address, data and sampled SDA.
`timescale 1ns / 1ps

interface i2cebm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] mem_address;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, cmd, mem_address, write_data, sda_in, input ready);
   modport sink   (input valid, cmd, mem_address, write_data, sda_in, output ready);
endinterface

@@ rtl/core/i2cebm_rsp_if.sv @@
// Response channel: pin levels, status and read byte for one tick.
`timescale 1ns / 1ps

interface i2cebm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_byte;

   modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte,
                   input ready);
   modport sink   (input valid, scl_level, sda_level, busy_res, done_res, read_byte,
                   output ready);
endinterface

@@ rtl/core/i2cebm_step.sv @@
// Next-state logic of the bus sequencer for one tick.
`timescale 1ns / 1ps

module i2cebm_step
   import i2cebm_pkg::*;
(
   input  state_type  st,
   input  cfg_type    cfg,
   input  logic [1:0] cmd,
   input  logic [7:0] mem_address,
   input  logic [7:0] write_data,
   input  logic       sda_in,
   output state_type  nx,
   output logic       done
);

   logic       go;
   logic [4:0] tgt;
   logic [7:0] limit;
   logic [8:0] hold_sum;

   always_comb begin
      nx       = st;
      done     = 1'b0;
      go       = 1'b0;
      tgt      = PH_IDLE;
      limit    = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
      hold_sum = {1'b0, st.hold} + 9'd1;

      case (st.phase)
         PH_IDLE: begin
            if (cmd == CMD_WRITE || cmd == CMD_READ) begin
               nx.op_read  = (cmd == CMD_READ);
               nx.address  = mem_address;
               nx.data     = write_data;
               nx.byte_idx = BYTE_DEVICE;
               nx.shift    = {cfg.device_address, 1'b0};
               nx.bit_cnt  = 3'd0;
               go          = 1'b1;
               tgt         = PH_ST_SDA_HI;
            end
         end
         PH_AK_WAIT: begin
            if (!sda_in) begin
               go  = 1'b1;
               tgt = PH_AK_SCL_LO;
            end else begin
               nx.ack_cnt = st.ack_cnt + 8'd1;
               if (nx.ack_cnt >= cfg.ack_wait_limit) begin
                  go  = 1'b1;
                  tgt = PH_AK_SCL_LO;
               end
            end
         end
         default: begin
            if (hold_sum >= {1'b0, limit}) begin
               go = 1'b1;
               case (st.phase)
                  PH_ST_SDA_HI:  tgt = PH_ST_SCL_HI;
                  PH_ST_SCL_HI:  tgt = PH_ST_SDA_LO;
                  PH_ST_SDA_LO:  tgt = PH_WB_SCL_LO;
                  PH_WB_SCL_LO:  tgt = PH_WB_SDA_BIT;
                  PH_WB_SDA_BIT: tgt = PH_WB_SCL_HI;
                  PH_WB_SCL_HI: begin
                     nx.shift = {st.shift[6:0], 1'b0};
                     if (st.bit_cnt == 3'd7) begin
                        nx.bit_cnt = 3'd0;
                        tgt        = PH_WE_SCL_LO;
                     end else begin
                        nx.bit_cnt = st.bit_cnt + 3'd1;
                        tgt        = PH_WB_SCL_LO;
                     end
                  end
                  PH_WE_SCL_LO:  tgt = PH_WE_SDA_HI;
                  PH_WE_SDA_HI:  tgt = PH_AK_SCL_HI;
                  PH_AK_SCL_HI: begin
                     if (!sda_in || cfg.ack_wait_limit == 8'd0) begin
                        tgt = PH_AK_SCL_LO;
                     end else begin
                        nx.ack_cnt = 8'd0;
                        tgt        = PH_AK_WAIT;
                     end
                  end
                  PH_AK_SCL_LO: begin
                     if (st.byte_idx == BYTE_DEVICE) begin
                        nx.byte_idx = BYTE_ADDRESS;
                        nx.shift    = st.address;
                        nx.bit_cnt  = 3'd0;
                        tgt         = PH_WB_SCL_LO;
                     end else if (!st.op_read) begin
                        if (st.byte_idx == BYTE_ADDRESS) begin
                           nx.byte_idx = BYTE_THIRD;
                           nx.shift    = st.data;
                           nx.bit_cnt  = 3'd0;
                           tgt         = PH_WB_SCL_LO;
                        end else begin
                           tgt = PH_SP_SDA_LO;
                        end
                     end else if (st.byte_idx == BYTE_ADDRESS) begin
                        nx.byte_idx = BYTE_THIRD;
                        nx.shift    = {cfg.device_address, 1'b1};
                        nx.bit_cnt  = 3'd0;
                        tgt         = PH_ST_SDA_HI;
                     end else begin
                        nx.shift   = 8'd0;
                        nx.bit_cnt = 3'd0;
                        tgt        = PH_RB_PREP;
                     end
                  end
                  PH_RB_PREP:    tgt = PH_RB_SCL_HI;
                  PH_RB_SCL_HI: begin
                     nx.shift = {st.shift[6:0], sda_in};
                     tgt      = PH_RB_SCL_LO;
                  end
                  PH_RB_SCL_LO: begin
                     if (st.bit_cnt == 3'd7) begin
                        nx.bit_cnt = 3'd0;
                        nx.rx_byte = st.shift;
                        tgt        = PH_NK_SDA_HI;
                     end else begin
                        nx.bit_cnt = st.bit_cnt + 3'd1;
                        tgt        = PH_RB_SCL_HI;
                     end
                  end
                  PH_NK_SDA_HI:  tgt = PH_NK_SCL_HI;
                  PH_NK_SCL_HI:  tgt = PH_NK_SCL_LO;
                  PH_NK_SCL_LO:  tgt = PH_SP_SDA_LO;
                  PH_SP_SDA_LO:  tgt = PH_SP_SCL_HI;
                  PH_SP_SCL_HI:  tgt = PH_SP_SDA_HI;
                  default: begin
                     tgt  = PH_IDLE;
                     done = 1'b1;
                  end
               endcase
            end else begin
               nx.hold = st.hold + 8'd1;
            end
         end
      endcase

      if (go) begin
         nx.phase = tgt;
         nx.hold  = 8'd0;
         case (tgt)
            PH_ST_SDA_HI, PH_WE_SDA_HI, PH_NK_SDA_HI, PH_SP_SDA_HI: nx.sda = 1'b1;
            PH_ST_SCL_HI, PH_WB_SCL_HI, PH_AK_SCL_HI, PH_RB_SCL_HI,
            PH_NK_SCL_HI, PH_SP_SCL_HI: nx.scl = 1'b1;
            PH_ST_SDA_LO, PH_SP_SDA_LO: nx.sda = 1'b0;
            PH_WB_SCL_LO, PH_WE_SCL_LO, PH_AK_SCL_LO, PH_RB_SCL_LO,
            PH_NK_SCL_LO: nx.scl = 1'b0;
            PH_WB_SDA_BIT: nx.sda = nx.shift[7];
            PH_RB_PREP: begin
               nx.scl = 1'b0;
               nx.sda = 1'b1;
            end
            default: ;
         endcase
      end
   end

endmodule

@@ rtl/core/i2c_eeprom_byte_master.sv @@
// I2C EEPROM random byte read/write master driven one tick per request beat.
//
// Each request beat is one tick of the bus sequencer and yields exactly one response
// beat with the SCL/SDA levels after that tick, busy, a one-tick done flag and the last
// read byte. The block takes one beat per clock cycle, a new request being taken
// whenever its single output register is empty or is being drained in the same cycle;
// the response appears there in the cycle after acceptance. Bus timing is counted in
// ticks: every pin phase lasts phase_ticks ticks and each acknowledge may add up to
// ack_wait_limit ticks. Commands arriving while a transfer runs are ignored.
`timescale 1ns / 1ps

module i2c_eeprom_byte_master
   import i2cebm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cebm_req_if.sink   req_if,
   i2cebm_rsp_if.source rsp_if,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   logic      done_in;
   logic      rsp_valid_ff;
   logic      scl_ff;
   logic      sda_ff;
   logic      busy_ff;
   logic      done_ff;
   logic [7:0] read_byte_ff;
   logic      req_take;

   i2cebm_step u_step (
      .st          (state_ff),
      .cfg         (cfg_ff),
      .cmd         (req_if.cmd),
      .mem_address (req_if.mem_address),
      .write_data  (req_if.write_data),
      .sda_in      (req_if.sda_in),
      .nx          (state_in),
      .done        (done_in)
   );

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= DEVICE_ADDRESS_RESET;
         cfg_ff.phase_ticks    <= PHASE_TICKS_RESET;
         cfg_ff.ack_wait_limit <= ACK_WAIT_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_ff.device_address <= csr_wdata[6:0];
            CSR_PHASE_TICKS:    cfg_ff.phase_ticks    <= csr_wdata;
            CSR_ACK_WAIT_LIMIT: cfg_ff.ack_wait_limit <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         scl_ff       <= state_in.scl;
         sda_ff       <= state_in.sda;
         busy_ff      <= (state_in.phase != PH_IDLE);
         done_ff      <= done_in;
         read_byte_ff <= state_in.rx_byte;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.scl_level = scl_ff;
   assign rsp_if.sda_level = sda_ff;
   assign rsp_if.busy_res  = busy_ff;
   assign rsp_if.done_res  = done_ff;
   assign rsp_if.read_byte = read_byte_ff;

endmodule

@@ rtl/core/i2cebm_checker.sv @@
// Port-level assertions for the I2C EEPROM byte master and their bind.
`timescale 1ns / 1ps

module i2cebm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       scl_level,
   input logic       sda_level,
   input logic       busy_res,
   input logic       done_res,
   input logic [7:0] read_byte
);

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res)
      else $error("done beat shows busy");

   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy_res |-> scl_level && sda_level)
      else $error("idle beat does not release both lines");

   a_no_take_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response is stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(scl_level) && $stable(sda_level)
         && $stable(busy_res) && $stable(done_res) && $stable(read_byte))
      else $error("stalled response beat changed");

endmodule

bind i2c_eeprom_byte_master i2cebm_checker u_i2cebm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .scl_level (rsp_if.scl_level),
   .sda_level (rsp_if.sda_level),
   .busy_res  (rsp_if.busy_res),
   .done_res  (rsp_if.done_res),
   .read_byte (rsp_if.read_byte)
);
